[design/bct_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bct_pkg
// Shared constants, request and direction codes, lane types and the
// saturating offset helper for the backlash compensation tracker.
// ----------------------------------------------------------------------------
package bct_pkg;

   localparam int NUM_CH = 6;              // lane slots present in the block
   localparam int AXES   = 6;              // axes in use, 1 .. NUM_CH
   localparam int POS_W  = 32;             // Q15.16 position width
   localparam int BL_W   = 20;             // backlash register width
   localparam int REQ_W  = 2;
   localparam int IDX_W  = $clog2(NUM_CH);
   localparam int DIR_W  = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_MOVE     = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RESET    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SYNC     = 2'd2;
   localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_POS = 2'd0;
   localparam logic [DIR_W-1:0] DIR_NEG = 2'd1;
   localparam logic [DIR_W-1:0] DIR_NEU = 2'd2;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct packed {
      logic            en;
      logic [BL_W-1:0] data;
   } csr_wr_type;

   typedef struct packed {
      logic             take;
      logic [REQ_W-1:0] req_type;
   } lane_ctl_type;

   typedef struct packed {
      logic    fire;
      pos_type comp;
   } lane_res_type;

   // previous target plus or minus backlash, clamped to the signed range
   function automatic pos_type offset_sat(input pos_type base,
                                          input logic [BL_W-1:0] amount,
                                          input logic negative);
      logic signed [POS_W:0] wide;
      logic signed [POS_W:0] delta;
      pos_type               result;
      delta = $signed({{(POS_W+1-BL_W){1'b0}}, amount});
      if (negative) begin
         wide = {base[POS_W-1], base} - delta;
      end else begin
         wide = {base[POS_W-1], base} + delta;
      end
      if (wide[POS_W] != wide[POS_W-1]) begin
         result = wide[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         result = wide[POS_W-1:0];
      end
      return result;
   endfunction

endpackage
`default_nettype wire

[design/bct_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bct_req_if
// Request channel: request code and six axis positions per beat.
// ----------------------------------------------------------------------------
interface bct_req_if;
   logic                    valid;
   logic                    ready;
   logic [bct_pkg::REQ_W-1:0] req_type;
   bct_pkg::pos_type        pos_axis0;
   bct_pkg::pos_type        pos_axis1;
   bct_pkg::pos_type        pos_axis2;
   bct_pkg::pos_type        pos_axis3;
   bct_pkg::pos_type        pos_axis4;
   bct_pkg::pos_type        pos_axis5;

   modport source (output valid, req_type, pos_axis0, pos_axis1, pos_axis2,
                   pos_axis3, pos_axis4, pos_axis5, input ready);
   modport sink (input valid, req_type, pos_axis0, pos_axis1, pos_axis2,
                 pos_axis3, pos_axis4, pos_axis5, output ready);
endinterface
`default_nettype wire

[design/bct_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bct_rsp_if
// Response channel: one compensation move point per axis per beat.
// ----------------------------------------------------------------------------
interface bct_rsp_if;
   logic             valid;
   logic             ready;
   bct_pkg::pos_type comp_axis0;
   bct_pkg::pos_type comp_axis1;
   bct_pkg::pos_type comp_axis2;
   bct_pkg::pos_type comp_axis3;
   bct_pkg::pos_type comp_axis4;
   bct_pkg::pos_type comp_axis5;

   modport source (output valid, comp_axis0, comp_axis1, comp_axis2, comp_axis3,
                   comp_axis4, comp_axis5, input ready);
   modport sink (input valid, comp_axis0, comp_axis1, comp_axis2, comp_axis3,
                 comp_axis4, comp_axis5, output ready);
endinterface
`default_nettype wire

[design/backlash_compensation_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// backlash_compensation_tracker
// Six-axis backlash tracker that emits a compensation move on reversal.
// ----------------------------------------------------------------------------
// Each request beat carries a code and six Q15.16 positions. A move beat
// compares every axis against its stored target in its own lane, all lanes
// in the same cycle; an axis with nonzero backlash that reverses, or moves
// first from neutral, gets its point pushed by its backlash (saturating).
// If any lane fired, one response beat holds all six points (a lane that
// did not fire reports its previous target). Reset and sync beats load the
// positions and never respond; code 3 is dropped. The block takes one beat
// per cycle: lane state updates on the accepting edge, and the response
// sits in a single output register, so a request is held off only while
// that register is full and the response side is stalling. The user must
// write the backlash registers through csr_we / csr_index / csr_wdata only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module backlash_compensation_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [bct_pkg::IDX_W-1:0]   csr_index,
   input  logic [bct_pkg::BL_W-1:0]    csr_wdata,
   bct_req_if.sink                     req_bus,
   bct_rsp_if.source                   rsp_bus
);

   bct_pkg::pos_type      pos_vec  [bct_pkg::NUM_CH];
   bct_pkg::lane_res_type lane_res [bct_pkg::NUM_CH];
   bct_pkg::lane_ctl_type lane_ctl;
   logic                  stage_free;
   logic                  take;
   logic                  any_fire;

   // flatten the per-axis payload fields into a lane vector
   always_comb begin
      pos_vec[0] = req_bus.pos_axis0;
      pos_vec[1] = req_bus.pos_axis1;
      pos_vec[2] = req_bus.pos_axis2;
      pos_vec[3] = req_bus.pos_axis3;
      pos_vec[4] = req_bus.pos_axis4;
      pos_vec[5] = req_bus.pos_axis5;
   end

   // accept whenever the output register can hold a new response
   assign req_bus.ready     = stage_free;
   assign take              = req_bus.valid && stage_free;
   assign lane_ctl.take     = take;
   assign lane_ctl.req_type = req_bus.req_type;

   for (genvar i = 0; i < bct_pkg::NUM_CH; i++) begin : g_lane
      if (i < bct_pkg::AXES) begin : g_used
         bct_pkg::csr_wr_type csr_wr;
         assign csr_wr.en   = csr_we && (csr_index == bct_pkg::IDX_W'(i));
         assign csr_wr.data = csr_wdata;

         bct_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .csr_wr (csr_wr),
            .ctl    (lane_ctl),
            .pos    (pos_vec[i]),
            .res    (lane_res[i])
         );
      end else begin : g_unused
         // axis not in use: never fire, report zero
         assign lane_res[i] = '0;
      end
   end

   bct_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .lane_res   (lane_res),
      .stage_free (stage_free),
      .rsp        (rsp_bus)
   );

   always_comb begin
      any_fire = 1'b0;
      for (int i = 0; i < bct_pkg::NUM_CH; i++) begin
         any_fire = any_fire | lane_res[i].fire;
      end
   end

   // a move beat with a firing lane must produce a response next cycle
   a_fire_responds: assert property (@(posedge clock) disable iff (reset)
      (take && any_fire) |=> rsp_bus.valid)
      else $error("firing move beat produced no response");

   // non-move beats never respond; with the sink ready the register drains
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (take && (req_bus.req_type != bct_pkg::REQ_MOVE) && rsp_bus.ready)
      |=> !rsp_bus.valid)
      else $error("non-move beat produced a response");

   // requests are held off only behind a stalled full output register
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (rsp_bus.valid && !rsp_bus.ready))
      else $error("request stalled without output stall");

endmodule
`default_nettype wire

[design/bct_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bct_lane
// One axis: backlash register, last target, direction, and the reversal
// check that yields this axis's compensation point.
// ----------------------------------------------------------------------------
module bct_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  bct_pkg::csr_wr_type   csr_wr,
   input  bct_pkg::lane_ctl_type ctl,
   input  bct_pkg::pos_type      pos,
   output bct_pkg::lane_res_type res
);

   logic [bct_pkg::BL_W-1:0]  backlash_ff, backlash_in;
   bct_pkg::pos_type          last_target_ff, last_target_in;
   logic [bct_pkg::DIR_W-1:0] move_dir_ff, move_dir_in;

   logic is_move;
   logic enabled;
   logic goes_up;
   logic goes_down;

   always_comb begin
      is_move   = (ctl.req_type == bct_pkg::REQ_MOVE);
      enabled   = (backlash_ff != '0);
      goes_up   = (pos > last_target_ff);
      goes_down = (pos < last_target_ff);

      res.fire = is_move && enabled &&
                 ((goes_up && (move_dir_ff != bct_pkg::DIR_POS)) ||
                  (goes_down && (move_dir_ff != bct_pkg::DIR_NEG)));
      if (res.fire) begin
         res.comp = bct_pkg::offset_sat(last_target_ff, backlash_ff, goes_down);
      end else begin
         res.comp = last_target_ff;
      end
   end

   always_comb begin
      backlash_in    = backlash_ff;
      last_target_in = last_target_ff;
      move_dir_in    = move_dir_ff;
      if (csr_wr.en) begin
         backlash_in = csr_wr.data;
      end
      if (ctl.take) begin
         case (ctl.req_type)
            bct_pkg::REQ_MOVE: begin
               last_target_in = pos;
               if (enabled && goes_up) begin
                  move_dir_in = bct_pkg::DIR_POS;
               end else if (enabled && goes_down) begin
                  move_dir_in = bct_pkg::DIR_NEG;
               end
            end
            bct_pkg::REQ_RESET: begin
               last_target_in = pos;
               move_dir_in    = bct_pkg::DIR_NEU;
            end
            bct_pkg::REQ_SYNC: begin
               last_target_in = pos;
            end
            default: begin
               // unused code: leave state alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backlash_ff    <= '0;
         last_target_ff <= '0;
         move_dir_ff    <= bct_pkg::DIR_NEU;
      end else begin
         backlash_ff    <= backlash_in;
         last_target_ff <= last_target_in;
         move_dir_ff    <= move_dir_in;
      end
   end

endmodule
`default_nettype wire

[design/bct_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bct_merge
// Combine lane results into one response beat and hold it in the output
// register until taken.
// ----------------------------------------------------------------------------
module bct_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  bct_pkg::lane_res_type lane_res [bct_pkg::NUM_CH],
   output logic                  stage_free,
   bct_rsp_if.source             rsp
);

   logic             rsp_valid_ff, rsp_valid_in;
   bct_pkg::pos_type comp_ff [bct_pkg::NUM_CH];
   bct_pkg::pos_type comp_in [bct_pkg::NUM_CH];
   logic             any_fire;

   always_comb begin
      any_fire = 1'b0;
      for (int i = 0; i < bct_pkg::NUM_CH; i++) begin
         any_fire = any_fire | lane_res[i].fire;
      end
      stage_free   = !rsp_valid_ff || rsp.ready;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      comp_in      = comp_ff;
      if (take && any_fire) begin
         rsp_valid_in = 1'b1;
         for (int i = 0; i < bct_pkg::NUM_CH; i++) begin
            comp_in[i] = lane_res[i].comp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      comp_ff <= comp_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.comp_axis0 = comp_ff[0];
   assign rsp.comp_axis1 = comp_ff[1];
   assign rsp.comp_axis2 = comp_ff[2];
   assign rsp.comp_axis3 = comp_ff[3];
   assign rsp.comp_axis4 = comp_ff[4];
   assign rsp.comp_axis5 = comp_ff[5];

endmodule
`default_nettype wire

[test/tb_backlash_compensation_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_backlash_compensation_tracker
// Self-checking bench for the six-axis backlash tracker: directed beats walk
// through first moves, reversals, equal targets, loads, dropped codes,
// saturated offsets and unmapped register writes, then random beats run
// under several backlash settings with bursty requests and a stalling
// response side. Every compensation move is compared axis by axis against
// an in-bench tracker model.
// ----------------------------------------------------------------------------
module tb_backlash_compensation_tracker;

   // packed views of one request beat and one set of compensation points
   typedef bct_pkg::pos_type [bct_pkg::NUM_CH-1:0] point_set_type;
   typedef struct packed {
      logic [bct_pkg::REQ_W-1:0] code;
      point_set_type             pos;
   } req_beat_type;

   localparam bct_pkg::pos_type POS_MAX = 32'sh7FFF_FFFF;
   localparam bct_pkg::pos_type POS_MIN = 32'sh8000_0000;
   localparam logic signed [bct_pkg::POS_W+1:0] SUM_CEIL  = 34'sd2147483647;
   localparam logic signed [bct_pkg::POS_W+1:0] SUM_FLOOR = -34'sd2147483648;
   localparam logic [bct_pkg::BL_W-1:0] BL_FULL  = '1;           // above documented range
   localparam logic [bct_pkg::BL_W-1:0] BL_TOP   = 20'd655360;   // 10 mm
   localparam logic [bct_pkg::BL_W-1:0] BL_MM    = 20'd65536;    // 1 mm
   localparam logic [bct_pkg::IDX_W-1:0] BACKLASH_REG_BASE  = '0;
   localparam logic [bct_pkg::IDX_W-1:0] UNMAPPED_REG_FIRST =
      bct_pkg::IDX_W'(bct_pkg::NUM_CH);
   localparam logic [bct_pkg::IDX_W-1:0] UNMAPPED_REG_LAST  = '1;
   localparam int PHASE_BEATS  = 200;   // counted beats per random setting
   localparam int DRAIN_CYCLES = 4;     // response lands in the cycle after its beat
   localparam int IDLE_LIMIT   = 4000;  // cycles without any accepted beat
   localparam int REPORT_MAX   = 10;

   logic clock;
   logic reset;
   logic csr_we;
   logic [bct_pkg::IDX_W-1:0] csr_index;
   logic [bct_pkg::BL_W-1:0]  csr_wdata;

   bct_req_if req_ch ();
   bct_rsp_if rsp_ch ();

   backlash_compensation_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // tracker model: stored targets, travel directions and backlash registers
   bct_pkg::pos_type          last_pos   [bct_pkg::NUM_CH];
   logic [bct_pkg::DIR_W-1:0] heading    [bct_pkg::NUM_CH];
   logic [bct_pkg::BL_W-1:0]  backlash_q [bct_pkg::NUM_CH];

   // compensation moves predicted but not yet seen on the response side
   point_set_type pending_points [$];

   // stimulus state: positions as the block should hold them after each beat
   bct_pkg::pos_type walk_pos [bct_pkg::NUM_CH];

   int burst_left;
   int idle_cycles;
   int faults;
   int move_beats;
   int load_beats;
   int dropped_beats;
   int points_checked;
   int settings_run;

   // receiver stall pattern
   int rx_mode;
   int rx_tick;
   int stall_left;

   // ---------------------------------------------------------------------------
   // Model
   // ---------------------------------------------------------------------------

   // push a stored target by the backlash, clamped to the Q15.16 range
   function automatic bct_pkg::pos_type push_point(input bct_pkg::pos_type base,
                                                   input logic [bct_pkg::BL_W-1:0] amount,
                                                   input logic downward);
      logic signed [bct_pkg::POS_W+1:0] sum;
      logic signed [bct_pkg::POS_W+1:0] step;
      sum  = {{2{base[bct_pkg::POS_W-1]}}, base};
      step = {{(bct_pkg::POS_W+2-bct_pkg::BL_W){1'b0}}, amount};
      sum  = downward ? sum - step : sum + step;
      if (sum > SUM_CEIL) begin
         return POS_MAX;
      end else if (sum < SUM_FLOOR) begin
         return POS_MIN;
      end
      return sum[bct_pkg::POS_W-1:0];
   endfunction

   // apply one accepted beat; returns 1 when a compensation move is due
   function automatic logic advance_tracker(input req_beat_type beat,
                                            output point_set_type points);
      logic             fired;
      bct_pkg::pos_type target;
      fired  = 1'b0;
      points = '0;
      if (beat.code != bct_pkg::REQ_RESERVED) begin
         for (int a = 0; a < bct_pkg::AXES; a++) begin
            target = beat.pos[a];
            if (beat.code == bct_pkg::REQ_MOVE) begin
               points[a] = last_pos[a];
               // an axis with zero backlash keeps its direction untouched
               if (backlash_q[a] != '0) begin
                  if (target > last_pos[a]) begin
                     if (heading[a] != bct_pkg::DIR_POS) begin
                        points[a] = push_point(last_pos[a], backlash_q[a], 1'b0);
                        fired     = 1'b1;
                     end
                     heading[a] = bct_pkg::DIR_POS;
                  end else if (target < last_pos[a]) begin
                     if (heading[a] != bct_pkg::DIR_NEG) begin
                        points[a] = push_point(last_pos[a], backlash_q[a], 1'b1);
                        fired     = 1'b1;
                     end
                     heading[a] = bct_pkg::DIR_NEG;
                  end
               end
            end else if (beat.code == bct_pkg::REQ_RESET) begin
               heading[a] = bct_pkg::DIR_NEU;
            end
            last_pos[a] = target;
         end
      end
      return fired;
   endfunction

   function automatic void note_fault(input string msg);
      faults++;
      if (faults <= REPORT_MAX) begin
         $display("MISMATCH: %s", msg);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: predict on every accepted request, check every accepted response
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      req_beat_type  beat;
      point_set_type points;
      point_set_type got;
      point_set_type want;
      logic          moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            moved     = 1'b1;
            beat.code = req_ch.req_type;
            beat.pos  = {req_ch.pos_axis5, req_ch.pos_axis4, req_ch.pos_axis3,
                         req_ch.pos_axis2, req_ch.pos_axis1, req_ch.pos_axis0};
            case (beat.code)
               bct_pkg::REQ_MOVE:                     move_beats++;
               bct_pkg::REQ_RESET, bct_pkg::REQ_SYNC: load_beats++;
               default:                               dropped_beats++;
            endcase
            if (advance_tracker(beat, points)) begin
               pending_points.push_back(points);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            got   = {rsp_ch.comp_axis5, rsp_ch.comp_axis4, rsp_ch.comp_axis3,
                     rsp_ch.comp_axis2, rsp_ch.comp_axis1, rsp_ch.comp_axis0};
            if (pending_points.size() == 0) begin
               note_fault($sformatf("unexpected compensation move, points %h", got));
            end else begin
               want = pending_points.pop_front();
               points_checked++;
               for (int a = 0; a < bct_pkg::NUM_CH; a++) begin
                  if (got[a] !== want[a]) begin
                     note_fault($sformatf("axis %0d point: expected %h, got %h",
                                          a, want[a], got[a]));
                  end
               end
            end
         end
         // watchdog: no progress on either side for too long ends the run
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles, %0d moves outstanding",
                     idle_cycles, pending_points.size());
            $display("backlash_compensation_tracker verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response side: stall on one of four patterns, chosen anew at random
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      logic take;
      take = 1'b1;
      if (stall_left != 0) begin
         // hold off through a long stall
         stall_left--;
         take = 1'b0;
      end else begin
         case (rx_mode)
            0: take = 1'b1;
            1: take = 1'($urandom_range(0, 1));
            2: take = (rx_tick % 4) == 0;
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  take       = 1'b0;
                  stall_left = $urandom_range(3, 23);
               end
            end
         endcase
      end
      rx_tick++;
      if (rx_tick % 300 == 0) begin
         rx_mode = $urandom_range(0, 3);
      end
      rsp_ch.ready <= take;
   end

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // present one beat and hold it until the block takes it
   task automatic send_beat(input req_beat_type beat);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= beat.code;
      req_ch.pos_axis0 <= beat.pos[0];
      req_ch.pos_axis1 <= beat.pos[1];
      req_ch.pos_axis2 <= beat.pos[2];
      req_ch.pos_axis3 <= beat.pos[3];
      req_ch.pos_axis4 <= beat.pos[4];
      req_ch.pos_axis5 <= beat.pos[5];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // write one register; the enable stays up for back-to-back writes
   task automatic write_csr(input logic [bct_pkg::IDX_W-1:0] index,
                            input logic [bct_pkg::BL_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index < bct_pkg::NUM_CH) begin
         backlash_q[index] = value;
      end
      @(posedge clock);
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
   endtask

   // drop valid, let the monitor see the last beat, then wait out every
   // predicted move and the pipeline behind it
   task automatic settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_beat_type uniform_beat(input logic [bct_pkg::REQ_W-1:0] code,
                                                 input bct_pkg::pos_type target);
      req_beat_type beat;
      beat.code = code;
      for (int a = 0; a < bct_pkg::NUM_CH; a++) begin
         beat.pos[a] = target;
      end
      return beat;
   endfunction

   // mostly moves near the current targets so reversals are frequent;
   // some loads, dropped codes, wild jumps and range extremes mixed in
   task automatic draw_beat(output req_beat_type beat);
      int pick;
      int delta;
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
         beat.code = bct_pkg::REQ_MOVE;
      end else if (pick < 91) begin
         beat.code = bct_pkg::REQ_SYNC;
      end else if (pick < 96) begin
         beat.code = bct_pkg::REQ_RESET;
      end else begin
         beat.code = bct_pkg::REQ_RESERVED;
      end
      for (int a = 0; a < bct_pkg::NUM_CH; a++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            beat.pos[a] = walk_pos[a];
         end else if (pick < 75) begin
            delta = $urandom_range(1, 262144);
            beat.pos[a] = $urandom_range(0, 1) ? walk_pos[a] + delta : walk_pos[a] - delta;
         end else if (pick < 88) begin
            beat.pos[a] = $urandom;
         end else begin
            case ($urandom_range(0, 5))
               0: beat.pos[a] = POS_MAX;
               1: beat.pos[a] = POS_MIN;
               2: beat.pos[a] = POS_MAX - 1;
               3: beat.pos[a] = POS_MIN + 1;
               4: beat.pos[a] = '0;
               default: beat.pos[a] = '1;
            endcase
         end
         if (beat.code != bct_pkg::REQ_RESERVED) begin
            walk_pos[a] = beat.pos[a];
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // backlash is zero out of reset: no move may produce a compensation
   task automatic test_disabled_axes();
      send_beat(uniform_beat(bct_pkg::REQ_SYNC, 32'sh0001_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, 32'sh0002_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, 32'sh0000_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, -32'sh0005_0000));
      settle();
   endtask

   // first move from neutral, same direction, reversal, equal target,
   // dropped code, direction reset and position-only load
   task automatic test_reversal_sequence();
      write_csr(BACKLASH_REG_BASE + bct_pkg::IDX_W'(0), 20'd1);
      write_csr(BACKLASH_REG_BASE + bct_pkg::IDX_W'(1), BL_TOP);
      write_csr(BACKLASH_REG_BASE + bct_pkg::IDX_W'(2), BL_FULL);
      write_csr(BACKLASH_REG_BASE + bct_pkg::IDX_W'(3), BL_MM);
      write_csr(BACKLASH_REG_BASE + bct_pkg::IDX_W'(4), '0);
      write_csr(BACKLASH_REG_BASE + bct_pkg::IDX_W'(5), 20'd3277);
      end_writes();
      settings_run++;
      send_beat(uniform_beat(bct_pkg::REQ_RESET, 32'sh0000_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, 32'sh0003_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, 32'sh0004_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, -32'sh0001_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, -32'sh0001_0000));
      send_beat(uniform_beat(bct_pkg::REQ_RESERVED, 32'sh0700_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, 32'sh0001_0000));
      send_beat(uniform_beat(bct_pkg::REQ_RESET, 32'sh0005_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, 32'sh0005_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, 32'sh0004_0000));
      send_beat(uniform_beat(bct_pkg::REQ_SYNC, 32'sh0009_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, 32'sh0008_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, 32'sh000A_0000));
      settle();
   endtask

   // offsets that run past either end of the range must clamp
   task automatic test_saturated_offsets();
      send_beat(uniform_beat(bct_pkg::REQ_RESET, POS_MAX - 15));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, POS_MAX));
      send_beat(uniform_beat(bct_pkg::REQ_RESET, POS_MIN + 5));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, POS_MIN));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, POS_MAX));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, POS_MIN));
      settle();
   endtask

   // writes past the last backlash register must change nothing
   task automatic test_unmapped_registers();
      write_csr(UNMAPPED_REG_FIRST, BL_FULL);
      write_csr(UNMAPPED_REG_LAST, BL_TOP);
      end_writes();
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, 32'sh0000_0000));
      send_beat(uniform_beat(bct_pkg::REQ_MOVE, -32'sh0000_0001));
      settle();
   endtask

   // random traffic under a series of backlash settings, extremes included
   task automatic test_random_settings();
      req_beat_type             beat;
      logic [bct_pkg::BL_W-1:0] value;
      int                       counted;
      for (int phase = 0; phase < 8; phase++) begin
         for (int a = 0; a < bct_pkg::NUM_CH; a++) begin
            case (phase)
               0: value = '0;
               1: value = BL_FULL;
               2: value = BL_TOP;
               3: value = 20'd1;
               4: value = (a % 2 == 0) ? '0 : bct_pkg::BL_W'($urandom_range(1, 655360));
               5: value = bct_pkg::BL_W'($urandom_range(1, 655360));
               6: value = bct_pkg::BL_W'($urandom);
               default: begin
                  case (a)
                     0: value = 20'd1;
                     1: value = BL_FULL;
                     2: value = '0;
                     3: value = BL_TOP;
                     4: value = BL_MM;
                     default: value = bct_pkg::BL_W'($urandom);
                  endcase
               end
            endcase
            write_csr(BACKLASH_REG_BASE + bct_pkg::IDX_W'(a), value);
         end
         end_writes();
         settings_run++;
         counted = 0;
         while (counted < PHASE_BEATS) begin
            draw_beat(beat);
            send_beat(beat);
            // dropped codes do not count toward the phase
            if (beat.code != bct_pkg::REQ_RESERVED) begin
               counted++;
            end
         end
         settle();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = bct_pkg::REQ_MOVE;
      req_ch.pos_axis0 = '0;
      req_ch.pos_axis1 = '0;
      req_ch.pos_axis2 = '0;
      req_ch.pos_axis3 = '0;
      req_ch.pos_axis4 = '0;
      req_ch.pos_axis5 = '0;
      rsp_ch.ready     = 1'b0;
      burst_left       = 0;
      idle_cycles      = 0;
      faults           = 0;
      move_beats       = 0;
      load_beats       = 0;
      dropped_beats    = 0;
      points_checked   = 0;
      settings_run     = 1;
      rx_mode          = 0;
      rx_tick          = 0;
      stall_left       = 0;
      for (int a = 0; a < bct_pkg::NUM_CH; a++) begin
         last_pos[a]   = '0;
         heading[a]    = bct_pkg::DIR_NEU;
         backlash_q[a] = '0;
         walk_pos[a]   = '0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_axes();
      test_reversal_sequence();
      test_saturated_offsets();
      test_unmapped_registers();
      for (int a = 0; a < bct_pkg::NUM_CH; a++) begin
         walk_pos[a] = last_pos[a];
      end
      test_random_settings();
      settle();

      if (pending_points.size() != 0) begin
         note_fault($sformatf("%0d compensation moves never arrived",
                              pending_points.size()));
      end
      $display("covered %0d move, %0d load and %0d dropped beats over %0d backlash settings",
               move_beats, load_beats, dropped_beats, settings_run);
      $display("compared %0d compensation moves, %0d faults", points_checked, faults);
      if (faults == 0) begin
         $display("backlash_compensation_tracker verification clean");
      end else begin
         $display("backlash_compensation_tracker verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
design/bct_pkg.sv
design/bct_req_if.sv
design/bct_rsp_if.sv
design/bct_lane.sv
design/bct_merge.sv
design/backlash_compensation_tracker.sv
test/tb_backlash_compensation_tracker.sv
